[design/spiral_prime_matrix_fill_top_macros.svh]
// Assertion macros for the spiral prime fill top module.
// Macros expect signals named clk and rst_n in the scope where they are used.
`ifndef SPIRAL_PRIME_MATRIX_FILL_TOP_MACROS_SVH
`define SPIRAL_PRIME_MATRIX_FILL_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define SPMF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spmf assertion failed");

// Next-cycle implication, disabled while in reset
`define SPMF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spmf assertion failed");

`endif

[design/spmf_pkg.sv]
// Package for the spiral prime fill block: widths, microcode table, shared types.
// No dependencies; the design modules and channel interfaces use it.
package spmf_pkg;

    // Field and datapath widths
    localparam int MAX_SIDE   = 16;
    localparam int SIDE_W     = 5;
    localparam int ROW_W      = 4;
    localparam int BND_W      = ROW_W + 1;
    localparam int CELLS_W    = 9;
    localparam int CAND_W     = 11;
    localparam int DIV_W      = 6;
    localparam int SIDE_RESET = 16;

    // Sequencer geometry
    localparam int PC_W        = 3;
    localparam int UCODE_DEPTH = 1 << PC_W;
    localparam int COND_W      = 3;

    // Step addresses
    localparam logic [PC_W-1:0] S_IDLE  = 3'd0;
    localparam logic [PC_W-1:0] S_NEXT  = 3'd1;
    localparam logic [PC_W-1:0] S_SQ    = 3'd2;
    localparam logic [PC_W-1:0] S_START = 3'd3;
    localparam logic [PC_W-1:0] S_WAIT  = 3'd4;
    localparam logic [PC_W-1:0] S_CHECK = 3'd5;
    localparam logic [PC_W-1:0] S_INCD  = 3'd6;
    localparam logic [PC_W-1:0] S_EMIT  = 3'd7;

    // Jump conditions
    localparam logic [COND_W-1:0] C_NEVER    = 3'd0;
    localparam logic [COND_W-1:0] C_ALWAYS   = 3'd1;
    localparam logic [COND_W-1:0] C_NO_INPUT = 3'd2;
    localparam logic [COND_W-1:0] C_SQ_GT    = 3'd3;
    localparam logic [COND_W-1:0] C_DIV_BUSY = 3'd4;
    localparam logic [COND_W-1:0] C_REM_ZERO = 3'd5;
    localparam logic [COND_W-1:0] C_OUT_FULL = 3'd6;

    // One control word per step
    typedef struct packed {
        logic              accept;     // offer ready on the request channel
        logic              next_cand;  // candidate + 1, divisor back to 2
        logic              inc_div;    // divisor + 1
        logic              start_div;  // launch remainder unit
        logic              emit;       // load result register
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } ctrl_t;

    // Status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic sq_gt;
        logic div_busy;
        logic rem_zero;
        logic out_full;
    } status_t;

    // Spiral position handed to the datapath
    typedef struct packed {
        logic             pending;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        logic             last;
    } spiral_t;

    // Microprogram; falling through the last step wraps to S_IDLE
    localparam ctrl_t UCODE [UCODE_DEPTH] = '{
        '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, C_NO_INPUT, S_IDLE },  // S_IDLE
        '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, C_NEVER,    S_IDLE },  // S_NEXT
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, C_SQ_GT,    S_EMIT },  // S_SQ
        '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, C_NEVER,    S_IDLE },  // S_START
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, C_DIV_BUSY, S_WAIT },  // S_WAIT
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, C_REM_ZERO, S_NEXT },  // S_CHECK
        '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, C_ALWAYS,   S_SQ   },  // S_INCD
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, C_OUT_FULL, S_EMIT }   // S_EMIT
    };

    // Clamp the side register into 1..MAX_SIDE
    function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] s);
        logic [SIDE_W-1:0] r;
        r = s;
        if (s == '0)
        begin
            r = SIDE_W'(1);
        end
        else if (s > SIDE_W'(MAX_SIDE))
        begin
            r = SIDE_W'(MAX_SIDE);
        end
        return r;
    endfunction

endpackage

[design/spmf_channels.sv]
// Channel interfaces of the spiral prime fill block: request, result, config.
// Depends on spmf_pkg for field widths.
interface spmf_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface spmf_res_if;
    logic                      valid;
    logic                      ready;
    logic [spmf_pkg::ROW_W-1:0]  row;
    logic [spmf_pkg::ROW_W-1:0]  col;
    logic [spmf_pkg::CAND_W-1:0] prime_value;
    logic                      last;

    modport source (output valid, output row, output col, output prime_value,
                    output last, input ready);
    modport sink (input valid, input row, input col, input prime_value,
                  input last, output ready);
endinterface

interface spmf_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [spmf_pkg::SIDE_W-1:0] side;

    modport source (output valid, output side, input ready);
    modport sink (input valid, input side, output ready);
endinterface

[design/spmf_divrem.sv]
// Restoring remainder unit: one dividend bit per cycle while busy, all CAND_W bits per start.
// Depends on spmf_pkg.
module spmf_divrem (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [spmf_pkg::CAND_W-1:0] dividend,
    input  logic [spmf_pkg::DIV_W-1:0]  divisor,
    output logic                        busy,
    output logic [spmf_pkg::DIV_W-1:0]  rem
);
    import spmf_pkg::*;

    localparam int CNT_W = $clog2(CAND_W);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] rem_next;
    logic [CAND_W-1:0] sh_reg;
    logic [DIV_W-1:0] dvs_reg;
    logic [DIV_W:0]   trial;

    // Shift in the next dividend bit and subtract when it fits
    always_comb
    begin
        trial = {rem_reg, sh_reg[CAND_W-1]};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = DIV_W'(trial - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = trial[DIV_W-1:0];
        end
    end

    // Count iterations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(CAND_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Hold operands and partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            sh_reg  <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            sh_reg  <= {sh_reg[CAND_W-2:0], 1'b0};
        end
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;
endmodule

[design/spmf_spiral.sv]
// Spiral walker: bounds, direction, position and remaining cell count.
// Depends on spmf_pkg.
module spmf_spiral (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start_m,
    input  logic [spmf_pkg::SIDE_W-1:0] side_eff,
    input  logic                        adv,
    output spmf_pkg::spiral_t           pos
);
    import spmf_pkg::*;

    logic [ROW_W-1:0]   top_reg;
    logic [ROW_W-1:0]   left_reg;
    logic [BND_W-1:0]   bottom_reg;
    logic [BND_W-1:0]   right_reg;
    logic [1:0]         dir_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   col_reg;
    logic [CELLS_W-1:0] cells_reg;
    logic               pending_reg;
    logic [2*SIDE_W-1:0] side_sq;
    logic [BND_W-1:0]   side_m1;
    logic               is_last;

    assign side_sq = side_eff * side_eff;
    assign side_m1 = BND_W'(side_eff - SIDE_W'(1));
    assign is_last = (cells_reg <= CELLS_W'(1));

    // Start a matrix, or step one cell along the spiral
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg     <= '0;
            left_reg    <= '0;
            bottom_reg  <= BND_W'(SIDE_RESET - 1);
            right_reg   <= BND_W'(SIDE_RESET - 1);
            dir_reg     <= 2'd0;
            row_reg     <= '0;
            col_reg     <= '0;
            cells_reg   <= CELLS_W'(SIDE_RESET * SIDE_RESET);
            pending_reg <= 1'b1;
        end
        else if (start_m)
        begin
            top_reg     <= '0;
            left_reg    <= '0;
            bottom_reg  <= side_m1;
            right_reg   <= side_m1;
            dir_reg     <= 2'd0;
            row_reg     <= '0;
            col_reg     <= '0;
            cells_reg   <= CELLS_W'(side_sq);
            pending_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (is_last)
            begin
                cells_reg   <= '0;
                pending_reg <= 1'b1;
            end
            else
            begin
                cells_reg <= cells_reg - CELLS_W'(1);
                case (dir_reg)
                    2'd0:
                    begin
                        if ({1'b0, col_reg} < right_reg)
                        begin
                            col_reg <= col_reg + ROW_W'(1);
                        end
                        else
                        begin
                            top_reg <= top_reg + ROW_W'(1);
                            dir_reg <= 2'd1;
                            row_reg <= row_reg + ROW_W'(1);
                        end
                    end
                    2'd1:
                    begin
                        if ({1'b0, row_reg} < bottom_reg)
                        begin
                            row_reg <= row_reg + ROW_W'(1);
                        end
                        else
                        begin
                            right_reg <= right_reg - BND_W'(1);
                            dir_reg   <= 2'd2;
                            col_reg   <= col_reg - ROW_W'(1);
                        end
                    end
                    2'd2:
                    begin
                        if (col_reg > left_reg)
                        begin
                            col_reg <= col_reg - ROW_W'(1);
                        end
                        else
                        begin
                            bottom_reg <= bottom_reg - BND_W'(1);
                            dir_reg    <= 2'd3;
                            row_reg    <= row_reg - ROW_W'(1);
                        end
                    end
                    default:
                    begin
                        if (row_reg > top_reg)
                        begin
                            row_reg <= row_reg - ROW_W'(1);
                        end
                        else
                        begin
                            left_reg <= left_reg + ROW_W'(1);
                            dir_reg  <= 2'd0;
                            col_reg  <= col_reg + ROW_W'(1);
                        end
                    end
                endcase
            end
        end
    end

    assign pos.pending = pending_reg;
    assign pos.row     = row_reg;
    assign pos.col     = col_reg;
    assign pos.last    = is_last;
endmodule

[design/spmf_seq.sv]
// Microcode sequencer: step counter, control word lookup, conditional jumps.
// Depends on spmf_pkg for the microprogram and condition codes.
module spmf_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  spmf_pkg::status_t st,
    output spmf_pkg::ctrl_t   ctrl
);
    import spmf_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            take;

    assign ctrl = UCODE[pc_reg];

    // Decode the jump condition of the current step
    always_comb
    begin
        unique case (ctrl.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_INPUT: take = !st.in_valid;
            C_SQ_GT:    take = st.sq_gt;
            C_DIV_BUSY: take = st.div_busy;
            C_REM_ZERO: take = st.rem_zero;
            C_OUT_FULL: take = st.out_full;
            default:    take = 1'b0;
        endcase
    end

    // Jump or advance; the last step wraps to the first
    assign pc_next = take ? ctrl.target : pc_reg + PC_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end
endmodule

[design/spiral_prime_matrix_fill_top.sv]
// Spiral prime fill: each request transfer yields one cell of a clockwise spiral
// with the next prime. Uses spmf_pkg, spmf_channels, spmf_seq, spmf_divrem,
// spmf_spiral and the assertion macro header.
//
// Channels: req (restart bit), res (row, col, prime_value, last), cfg (side).
// A transfer happens on a rising edge with valid and ready high. cfg is always
// ready; a new side takes effect on the first cell of the next matrix.
// One request is worked at a time: ready is high only while the sequencer
// waits in its idle step. Each candidate is tried against divisors from 2 up
// while the divisor squared does not exceed it, one divisor at a time on the
// bit-serial remainder unit; a divisor that leaves no remainder ends the try.
// Results sit in an output register; the next request is taken and its prime
// searched while a result still waits, and the sequencer holds in its emit
// step only when the register is still full.
// Reset: side returns to 16 and the next request begins a new matrix at the
// top-left with prime 2. After the last cell, the next matrix starts by itself.
`include "spiral_prime_matrix_fill_top_macros.svh"

module spiral_prime_matrix_fill_top (
    input  logic       clk,
    input  logic       rst_n,
    spmf_req_if.sink   req,
    spmf_res_if.source res,
    spmf_cfg_if.sink   cfg
);
    import spmf_pkg::*;

    ctrl_t   ctrl;
    status_t st;
    spiral_t pos;

    logic [SIDE_W-1:0]  side_reg;
    logic [CAND_W-1:0]  cand_reg;
    logic [DIV_W-1:0]   div_reg;
    logic [2*DIV_W-1:0] div_sq;
    logic               div_busy;
    logic [DIV_W-1:0]   div_rem;
    logic               accept_fire;
    logic               emit_fire;
    logic               start_m;

    logic               out_valid_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [ROW_W-1:0]   out_col_reg;
    logic [CAND_W-1:0]  out_prime_reg;
    logic               out_last_reg;

    // Configuration register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SIDE_W'(SIDE_RESET);
        end
        else if (cfg.valid)
        begin
            side_reg <= cfg.side;
        end
    end

    // Handshake qualification
    assign req.ready   = ctrl.accept;
    assign accept_fire = ctrl.accept && req.valid;
    assign start_m     = accept_fire && (req.restart || pos.pending);
    assign emit_fire   = ctrl.emit && !st.out_full;

    // Status back to the sequencer
    assign div_sq      = div_reg * div_reg;
    assign st.in_valid = req.valid;
    assign st.sq_gt    = div_sq > {{(2*DIV_W-CAND_W){1'b0}}, cand_reg};
    assign st.div_busy = div_busy;
    assign st.rem_zero = (div_rem == '0);
    assign st.out_full = out_valid_reg && !res.ready;

    spmf_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .ctrl  (ctrl)
    );

    spmf_divrem u_divrem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.start_div),
        .dividend (cand_reg),
        .divisor  (div_reg),
        .busy     (div_busy),
        .rem      (div_rem)
    );

    spmf_spiral u_spiral (
        .clk      (clk),
        .rst_n    (rst_n),
        .start_m  (start_m),
        .side_eff (eff_side(side_reg)),
        .adv      (emit_fire),
        .pos      (pos)
    );

    // Candidate and trial divisor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg <= CAND_W'(1);
            div_reg  <= DIV_W'(2);
        end
        else if (start_m)
        begin
            cand_reg <= CAND_W'(1);
        end
        else if (ctrl.next_cand)
        begin
            cand_reg <= cand_reg + CAND_W'(1);
            div_reg  <= DIV_W'(2);
        end
        else if (ctrl.inc_div)
        begin
            div_reg <= div_reg + DIV_W'(1);
        end
    end

    // Output register: load on emit, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_row_reg   <= pos.row;
            out_col_reg   <= pos.col;
            out_prime_reg <= cand_reg;
            out_last_reg  <= pos.last;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.row         = out_row_reg;
    assign res.col         = out_col_reg;
    assign res.prime_value = out_prime_reg;
    assign res.last        = out_last_reg;

    // A result loaded is offered in the next cycle
    `SPMF_ASSERT_NEXT(a_emit_offers, emit_fire, res.valid)
    // A divisor is launched only on an idle remainder unit
    `SPMF_ASSERT_NOW(a_div_idle_start, ctrl.start_div, !div_busy)
    // Every emitted prime is at least two
    `SPMF_ASSERT_NOW(a_prime_ge2, emit_fire, cand_reg >= CAND_W'(2))
    // A new request is never taken while a divide is in flight
    `SPMF_ASSERT_NOW(a_no_accept_busy, accept_fire, !div_busy)
endmodule

[tb/testbench.sv]
// Self-checking testbench for spiral_prime_matrix_fill_top: sends cell requests,
// writes the side register between phases and checks every result transfer.
// Depends on spmf_pkg and the channel interfaces in spmf_channels.
module testbench;
    import spmf_pkg::*;

    localparam int     CLK_HALF     = 6;
    localparam int     ITEMS_TOTAL  = 1150;
    localparam int     HOLD_CYCLES  = 3000;
    localparam int     DRAIN_CYCLES = 200;
    localparam int     REPORT_CAP   = 200;
    localparam longint LIMIT_CYCLES = 12000000;

    typedef enum logic [1:0] {HEAD_RIGHT, HEAD_DOWN, HEAD_LEFT, HEAD_UP} heading_t;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  col;
        logic [CAND_W-1:0] prime_value;
        logic              last;
    } cell_t;

    // Tracks the spiral walk and prime sequence, holds the cells still due
    class spiral_cell_board;
        logic [SIDE_W-1:0] side_reg;
        int                top_bnd, bottom_bnd, left_bnd, right_bnd;
        heading_t          heading;
        int                cur_row, cur_col, cells_left, prime_cand;
        bit                matrix_due;
        cell_t             cells_due[$];
        int                errors;

        function new();
            side_reg   = SIDE_W'(SIDE_RESET);
            matrix_due = 1'b1;
            errors     = 0;
        endfunction

        function int outstanding();
            return cells_due.size();
        endfunction

        // Work out the cell and prime for one accepted request
        function void note_request(logic restart);
            cell_t c;
            int    sz;
            int    p;
            bit    composite;
            // open a new matrix, latching the clamped side
            if (restart || matrix_due)
            begin
                if (side_reg == '0)
                    sz = 1;
                else if (side_reg > MAX_SIDE)
                    sz = MAX_SIDE;
                else
                    sz = int'(side_reg);
                top_bnd    = 0;
                left_bnd   = 0;
                bottom_bnd = sz - 1;
                right_bnd  = sz - 1;
                heading    = HEAD_RIGHT;
                cur_row    = 0;
                cur_col    = 0;
                cells_left = sz * sz;
                prime_cand = 1;
                matrix_due = 1'b0;
            end
            // search the next prime by trial division
            p = prime_cand;
            do
            begin
                p++;
                composite = 1'b0;
                for (int d = 2; d * d <= p; d++)
                begin
                    if (p % d == 0)
                        composite = 1'b1;
                end
            end
            while (composite);
            prime_cand = p;
            c.row         = ROW_W'(cur_row);
            c.col         = ROW_W'(cur_col);
            c.prime_value = CAND_W'(p);
            c.last        = (cells_left <= 1);
            cells_due.push_back(c);
            // step the spiral, shrinking a bound at each turn
            if (c.last)
            begin
                cells_left = 0;
                matrix_due = 1'b1;
            end
            else
            begin
                cells_left--;
                case (heading)
                    HEAD_RIGHT:
                    begin
                        if (cur_col < right_bnd)
                            cur_col++;
                        else
                        begin
                            top_bnd++;
                            heading = HEAD_DOWN;
                            cur_row++;
                        end
                    end
                    HEAD_DOWN:
                    begin
                        if (cur_row < bottom_bnd)
                            cur_row++;
                        else
                        begin
                            right_bnd--;
                            heading = HEAD_LEFT;
                            cur_col--;
                        end
                    end
                    HEAD_LEFT:
                    begin
                        if (cur_col > left_bnd)
                            cur_col--;
                        else
                        begin
                            bottom_bnd--;
                            heading = HEAD_UP;
                            cur_row--;
                        end
                    end
                    default:
                    begin
                        if (cur_row > top_bnd)
                            cur_row--;
                        else
                        begin
                            left_bnd++;
                            heading = HEAD_RIGHT;
                            cur_col++;
                        end
                    end
                endcase
            end
        endfunction

        function void compare_field(string name, logic [CAND_W-1:0] want,
                                    logic [CAND_W-1:0] got);
            if (want !== got)
            begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, name, want, got);
            end
        endfunction

        // Compare one result transfer against the oldest cell due
        function void check_result(cell_t got);
            cell_t want;
            if (cells_due.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d",
                             $time, got.row, got.col, got.prime_value, got.last);
                return;
            end
            want = cells_due.pop_front();
            compare_field("row", want.row, got.row);
            compare_field("col", want.col, got.col);
            compare_field("prime_value", want.prime_value, got.prime_value);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    spmf_req_if req_ch ();
    spmf_res_if res_ch ();
    spmf_cfg_if cfg_ch ();

    spiral_cell_board board = new();

    bit     tx_quiet;
    bit     rx_quiet;
    bit     hold_request;
    int     items_sent;
    longint cycle_count;

    spiral_prime_matrix_fill_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    initial clk = 1'b0;

    always #CLK_HALF clk = ~clk;

    // Mostly no gap, some short ones, a few long ones
    function automatic int unsigned pick_gap(input bit quiet);
        int unsigned roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one request and hold it until the transfer
    task automatic send_request(input logic restart);
        int unsigned gap;
        gap = pick_gap(tx_quiet);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.restart <= restart;
        do
            @(posedge clk);
        while (!req_ch.ready);
        board.note_request(restart);
        items_sent++;
    endtask

    // Drain all results, then write the side register
    task automatic write_side(input logic [SIDE_W-1:0] value);
        req_ch.valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.side  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid  <= 1'b0;
        board.side_reg = value;
    endtask

    // Result side: check transfers, stall after some, honor a long hold-off
    initial
    begin
        cell_t       got;
        int unsigned stall_left;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                got.row         = res_ch.row;
                got.col         = res_ch.col;
                got.prime_value = res_ch.prime_value;
                got.last        = res_ch.last;
                board.check_result(got);
                stall_left = pick_gap(rx_quiet);
            end
            if (hold_request)
            begin
                res_ch.ready <= 1'b0;
                hold_request = 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                stall_left = 0;
            end
            else if (stall_left != 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Abort a run that hangs
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus: directed checks, one full largest matrix, then random phases
    initial
    begin
        logic [SIDE_W-1:0] side_pick;
        int unsigned       len;
        int unsigned       roll;
        bit                open_restart;
        rst_n = 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.restart <= 1'b0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.side    <= '0;
        tx_quiet     = 1'b0;
        rx_quiet     = 1'b0;
        hold_request = 1'b0;
        items_sent   = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset side, then restart in the middle of a matrix
        repeat (3) send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        // side write mid-matrix leaves it alone; zero side acts as one
        write_side(SIDE_W'(0));
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        write_side(SIDE_W'(1));
        send_request(1'b0);
        send_request(1'b1);
        // oversized side saturates
        write_side(SIDE_W'(31));
        send_request(1'b0);
        send_request(1'b0);
        // full small spiral through every heading, then the automatic restart
        write_side(SIDE_W'(3));
        send_request(1'b1);
        repeat (9) send_request(1'b0);

        // one whole largest matrix; the receiver holds off part way through
        write_side(SIDE_W'(MAX_SIDE));
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        send_request(1'b1);
        for (int i = 1; i < MAX_SIDE * MAX_SIDE; i++)
        begin
            if (i == 40)
                hold_request = 1'b1;
            if (i == 128)
            begin
                tx_quiet = 1'b0;
                rx_quiet = 1'b0;
            end
            send_request(1'b0);
        end

        // random phases: mostly whole small matrices, some large sides
        while (items_sent < ITEMS_TOTAL)
        begin
            roll = $urandom_range(0, 99);
            open_restart = 1'b0;
            if (roll < 8)
            begin
                side_pick = '0;
                len = $urandom_range(1, 5);
            end
            else if (roll < 32)
            begin
                if (roll < 16)
                    side_pick = SIDE_W'($urandom_range(17, 31));
                else if (roll < 22)
                    side_pick = SIDE_W'(MAX_SIDE);
                else
                    side_pick = SIDE_W'($urandom_range(9, 15));
                len = $urandom_range(5, 40);
                open_restart = ($urandom_range(0, 1) == 1);
            end
            else
            begin
                side_pick = SIDE_W'($urandom_range(1, 8));
                len = $urandom_range(1, 3 * side_pick * side_pick + 2);
            end
            write_side(side_pick);
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++)
                send_request((i == 0 && open_restart) || ($urandom_range(0, 99) < 3));
        end

        // wait for the last results, then a quiet tail
        req_ch.valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
